### hdl/mws_pkg.sv
package mws_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int IFRAC           = 24;
  localparam int PIPE_LATENCY    = 13;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 15;
  localparam int TANH_N          = 512;
  localparam int SIN_N           = 256;

  localparam logic signed [24:0] THR_Q  = 25'sd167772;
  localparam logic signed [21:0] GATE_Q = 22'sd1677722;
  localparam logic signed [24:0] C09_Q  = 25'sd15099494;
  localparam logic signed [24:0] C06_Q  = 25'sd10066330;
  localparam logic signed [25:0] C18_Q  = 26'sd30198989;
  localparam logic signed [22:0] C02_Q  = 23'sd3355443;
  localparam longint PI_Q30 = 64'sd3373259426;

  typedef enum logic [1:0] {
    MODE_TANH = 2'd0,
    MODE_CLIP = 2'd1,
    MODE_FOLD = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_DRIVE  = 3'd0,
    REG_RANGE  = 3'd1,
    REG_BLEND  = 3'd2,
    REG_VOLUME = 3'd3,
    REG_MODE   = 3'd4,
    REG_BYPASS = 3'd5
  } reg_idx_t;

  // Settings as the datapath sees them, already limited to their high values.
  typedef struct packed {
    logic [13:0] drive;
    logic [14:0] range;
    logic [12:0] blend;
    logic [13:0] volume;
    mode_t       mode;
    logic        bypass;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               gated;
    logic signed [24:0] clean;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic signed [29:0] pre;
    logic signed [31:0] targ;
    logic        [33:0] pp;
  } front_t;

  typedef struct packed {
    side_t              side;
    logic signed [29:0] y;
  } shaped_t;

  typedef logic [24:0] rom_word_t;
  typedef rom_word_t tanh_tab_t [0:TANH_N];
  typedef rom_word_t sin_tab_t [0:SIN_N];

  // Rounds p / 2^sh to nearest, ties away from zero.
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] p,
                                                      input int unsigned sh);
    logic [63:0] m;
    logic [63:0] r;
    m = p[63] ? 64'(-p) : 64'(p);
    r = (m + (64'd1 << (sh - 1))) >> sh;
    return p[63] ? -signed'(r) : signed'(r);
  endfunction

  // Moves a stage's side data on; the valid bit clears while reset is held.
  function automatic side_t side_advance(input side_t s, input logic run);
    side_t o;
    o       = s;
    o.valid = s.valid && run;
    return o;
  endfunction

  // Long division by shift and subtract, for building the tables.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      q   = {q[62:0], 1'b0};
      if (rem >= den) begin
        rem  = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tanh_tab_t build_tanh();
    tanh_tab_t tab;
    longint one30;
    longint term;
    longint r;
    longint e;
    longint den;
    one30 = longint'(1) << 30;
    term  = one30;
    r     = one30;
    e     = one30;
    for (int n = 1; n <= 8; n++) begin
      term = longint'(udiv(term + 16 * n, 32 * n));
      r    = ((n & 1) == 1) ? r - term : r + term;
    end
    for (int k = 0; k <= TANH_N; k++) begin
      den    = one30 + e;
      tab[k] = rom_word_t'(udiv(((one30 - e) << IFRAC) + den / 2, den));
      e      = (e * r + (one30 >>> 1)) >>> 30;
    end
    return tab;
  endfunction

  function automatic sin_tab_t build_sin();
    sin_tab_t tab;
    longint one30;
    longint th;
    longint th2;
    longint t;
    longint sum;
    longint d;
    one30 = longint'(1) << 30;
    for (int k = 0; k <= SIN_N; k++) begin
      th  = (PI_Q30 * k + 256) / 512;
      th2 = (th * th + (one30 >>> 1)) >>> 30;
      t   = th;
      sum = th;
      for (int n = 1; n <= 9; n++) begin
        d   = longint'(2 * n) * (2 * n + 1);
        t   = (t * th2 + (one30 >>> 1)) >>> 30;
        t   = longint'(udiv(t + d / 2, d));
        sum = ((n & 1) == 1) ? sum - t : sum + t;
      end
      tab[k] = rom_word_t'((sum + 32) >>> 6);
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_ROM = build_tanh();
  localparam sin_tab_t  SIN_ROM  = build_sin();

endpackage

### hdl/mws_front.sv
module mws_front #(
  parameter int SAMPLE_BITS = mws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  mws_pkg::cfg_t                 cfg,
  output mws_pkg::front_t               front
);

  localparam int OSH = mws_pkg::IFRAC + 1 - SAMPLE_BITS;

  mws_pkg::side_t     s1_side_r, s2_side_r, s3_side_r;
  mws_pkg::side_t     s1_side_nxt;
  logic signed [29:0] s2_pre_r, s3_pre_r;
  logic signed [31:0] s3_targ_r;
  logic        [33:0] s3_pp_r;

  logic signed [24:0] x;
  logic               gate_hit;
  logic signed [46:0] gprod;
  logic        [16:0] range5;
  logic signed [42:0] pprod;
  logic signed [29:0] pre_nxt;
  logic        [13:0] gd;
  logic signed [44:0] a0prod;
  logic signed [54:0] a1prod;
  logic signed [59:0] sqprod;
  logic signed [31:0] targ_nxt;
  logic        [33:0] pp_nxt;

  // Stage 1: widen to 24 fraction bits and apply the noise gate.
  always_comb begin
    x        = 25'(sample) <<< OSH;
    gate_hit = (x < mws_pkg::THR_Q) && (x > -mws_pkg::THR_Q);
    gprod    = x * mws_pkg::GATE_Q;
    s1_side_nxt.valid = take;
    if (cfg.bypass) begin
      s1_side_nxt.gated = 1'b0;
      s1_side_nxt.clean = x;
    end else begin
      s1_side_nxt.gated = gate_hit;
      s1_side_nxt.clean = gate_hit ? 25'(mws_pkg::round_shift(64'(gprod), 24)) : x;
    end
  end

  // Stage 2: pre-gain by five times range.
  always_comb begin
    range5  = {cfg.range, 2'b00} + 17'(cfg.range);
    pprod   = s1_side_r.clean * $signed({1'b0, range5});
    pre_nxt = 30'(mws_pkg::round_shift(64'(pprod), 12));
  end

  // Stage 3: tanh argument for the two tanh modes and the square for the fold.
  always_comb begin
    gd     = cfg.drive + 14'd4096;
    a0prod = s2_pre_r * $signed({1'b0, gd});
    a1prod = s2_pre_r * mws_pkg::C06_Q;
    sqprod = s2_pre_r * s2_pre_r;
    if (cfg.mode == mws_pkg::MODE_CLIP) begin
      targ_nxt = 32'(mws_pkg::round_shift(64'(a1prod), 24));
    end else begin
      targ_nxt = 32'(mws_pkg::round_shift(64'(a0prod), 12));
    end
    pp_nxt = 34'(mws_pkg::round_shift(64'(sqprod), 24));
  end

  always_ff @(posedge clk) begin
    s1_side_r <= mws_pkg::side_advance(s1_side_nxt, rst_n);
    s2_side_r <= mws_pkg::side_advance(s1_side_r, rst_n);
    s2_pre_r  <= pre_nxt;
    s3_side_r <= mws_pkg::side_advance(s2_side_r, rst_n);
    s3_pre_r  <= s2_pre_r;
    s3_targ_r <= targ_nxt;
    s3_pp_r   <= pp_nxt;
  end

  assign front.side = s3_side_r;
  assign front.pre  = s3_pre_r;
  assign front.targ = s3_targ_r;
  assign front.pp   = s3_pp_r;

endmodule

### hdl/mws_shaper.sv
module mws_shaper (
  input  logic             clk,
  input  logic             rst_n,
  input  mws_pkg::front_t  front,
  input  mws_pkg::cfg_t    cfg,
  output mws_pkg::shaped_t shaped
);

  mws_pkg::side_t h1_side_r, h2_side_r, h3_side_r, h4_side_r, h5_side_r, h6_side_r;
  logic signed [29:0] h1_pre_r, h2_pre_r, h3_pre_r, h4_pre_r, h5_pre_r;

  logic [24:0] h1_tlo_r, h1_thi_r;
  logic [17:0] h1_tfr_r;
  logic        h1_tneg_r;
  logic [45:0] h1_plo_r, h1_phi_r;
  logic        h1_pneg_r;

  logic signed [25:0] h2_t_r;
  logic signed [38:0] h2_p3_r;

  logic signed [25:0] h3_ty_r;
  logic signed [36:0] h3_f_r;

  logic signed [24:0] h4_yclip_r, h5_yclip_r;
  logic        [24:0] h4_ph_r;

  logic [24:0] h5_slo_r, h5_shi_r;
  logic [14:0] h5_sfr_r;
  logic        h5_sneg_r;

  logic signed [29:0] h6_y_r;

  logic [30:0] tmag;
  logic        tsat;
  logic [9:0]  tlo_addr, thi_addr;
  logic [28:0] pmag;

  logic [24:0]        td;
  logic [43:0]        tprod;
  logic [24:0]        tv;
  logic signed [25:0] t_nxt;
  logic [62:0]        psum;
  logic [37:0]        p3m;
  logic signed [38:0] p3_nxt;

  logic signed [50:0] y0prod;
  logic signed [51:0] y1prod;
  logic signed [25:0] ty_nxt;
  logic signed [61:0] qprod;
  logic signed [36:0] q;
  logic signed [36:0] f_nxt;

  logic [14:0]        gc;
  logic signed [41:0] cprod;
  logic signed [28:0] yc;
  logic signed [24:0] yclip_nxt;
  logic [13:0]        gd;
  logic signed [51:0] uprod;
  logic [24:0]        ph_nxt;

  logic        sneg;
  logic [23:0] pf;
  logic [23:0] pfold;
  logic [8:0]  slo_addr, shi_addr;

  logic [24:0]        sd;
  logic [40:0]        sprod;
  logic [24:0]        sv;
  logic signed [25:0] ss;
  logic signed [24:0] sclamp;
  logic signed [29:0] y_nxt;

  // Stage 1: tanh table address, cube partial products.
  always_comb begin
    tmag     = front.targ[31] ? 31'(-front.targ) : 31'(front.targ);
    tsat     = tmag >= 31'd134217728;
    tlo_addr = tsat ? 10'(mws_pkg::TANH_N) : {1'b0, tmag[26:18]};
    thi_addr = tsat ? 10'(mws_pkg::TANH_N) : {1'b0, tmag[26:18]} + 10'd1;
    pmag     = front.pre[29] ? 29'(-front.pre) : 29'(front.pre);
  end

  always_ff @(posedge clk) begin
    h1_tlo_r  <= mws_pkg::TANH_ROM[tlo_addr];
    h1_thi_r  <= mws_pkg::TANH_ROM[thi_addr];
    h1_tfr_r  <= tsat ? 18'd0 : tmag[17:0];
    h1_tneg_r <= front.targ[31];
    h1_plo_r  <= front.pp[16:0] * pmag;
    h1_phi_r  <= front.pp[33:17] * pmag;
    h1_pneg_r <= front.pre[29];
  end

  // Stage 2: tanh interpolation, cube assembly.
  always_comb begin
    td     = h1_thi_r - h1_tlo_r;
    tprod  = td * h1_tfr_r;
    tv     = h1_tlo_r + 25'((tprod + 44'd131072) >> 18);
    t_nxt  = h1_tneg_r ? -$signed({1'b0, tv}) : $signed({1'b0, tv});
    psum   = (63'(h1_phi_r) << 17) + 63'(h1_plo_r);
    p3m    = 38'((psum + 63'd8388608) >> 24);
    p3_nxt = h1_pneg_r ? -$signed({1'b0, p3m}) : $signed({1'b0, p3m});
  end

  // Stage 3: tanh output scale, fold polynomial.
  always_comb begin
    y0prod = h2_t_r * mws_pkg::C09_Q;
    y1prod = h2_t_r * mws_pkg::C18_Q;
    if (cfg.mode == mws_pkg::MODE_CLIP) begin
      ty_nxt = 26'(mws_pkg::round_shift(64'(y1prod), 24));
    end else begin
      ty_nxt = 26'(mws_pkg::round_shift(64'(y0prod), 24));
    end
    qprod = h2_p3_r * mws_pkg::C02_Q;
    q     = 37'(mws_pkg::round_shift(64'(qprod), 24));
    f_nxt = 37'(h2_pre_r) - q;
  end

  // Stage 4: clip drive gain and clamp, fold phase in half-turns.
  always_comb begin
    gc    = {cfg.drive, 1'b0} + 15'd4096;
    cprod = h3_ty_r * $signed({1'b0, gc});
    yc    = 29'(mws_pkg::round_shift(64'(cprod), 12));
    if (cfg.mode == mws_pkg::MODE_CLIP) begin
      if (yc > mws_pkg::C09_Q) begin
        yclip_nxt = mws_pkg::C09_Q;
      end else if (yc < -mws_pkg::C09_Q) begin
        yclip_nxt = -mws_pkg::C09_Q;
      end else begin
        yclip_nxt = yc[24:0];
      end
    end else begin
      yclip_nxt = h3_ty_r[24:0];
    end
    gd     = cfg.drive + 14'd4096;
    uprod  = h3_f_r * $signed({1'b0, gd});
    ph_nxt = 25'(mws_pkg::round_shift(64'(uprod), 13));
  end

  // Stage 5: fold the phase onto a quarter wave and read the sine table.
  always_comb begin
    sneg     = h4_ph_r[24];
    pf       = h4_ph_r[23:0];
    pfold    = (pf > 24'd8388608) ? 24'd0 - pf : pf;
    slo_addr = pfold[23:15];
    shi_addr = (pfold[23:15] == 9'(mws_pkg::SIN_N)) ? 9'(mws_pkg::SIN_N)
                                                     : pfold[23:15] + 9'd1;
  end

  always_ff @(posedge clk) begin
    h5_slo_r  <= mws_pkg::SIN_ROM[slo_addr];
    h5_shi_r  <= mws_pkg::SIN_ROM[shi_addr];
    h5_sfr_r  <= pfold[14:0];
    h5_sneg_r <= sneg;
  end

  // Stage 6: sine interpolation and clamp, then pick the curve.
  always_comb begin
    sd    = h5_shi_r - h5_slo_r;
    sprod = sd * h5_sfr_r;
    sv    = h5_slo_r + 25'((sprod + 41'd16384) >> 15);
    ss    = h5_sneg_r ? -$signed({1'b0, sv}) : $signed({1'b0, sv});
    if (ss > mws_pkg::C09_Q) begin
      sclamp = mws_pkg::C09_Q;
    end else if (ss < -mws_pkg::C09_Q) begin
      sclamp = -mws_pkg::C09_Q;
    end else begin
      sclamp = ss[24:0];
    end
    case (cfg.mode)
      mws_pkg::MODE_TANH, mws_pkg::MODE_CLIP: y_nxt = 30'(h5_yclip_r);
      mws_pkg::MODE_FOLD:                     y_nxt = 30'(sclamp);
      default:                                y_nxt = h5_pre_r;
    endcase
  end

  always_ff @(posedge clk) begin
    h1_side_r  <= mws_pkg::side_advance(front.side, rst_n);
    h1_pre_r   <= front.pre;
    h2_side_r  <= mws_pkg::side_advance(h1_side_r, rst_n);
    h2_pre_r   <= h1_pre_r;
    h2_t_r     <= t_nxt;
    h2_p3_r    <= p3_nxt;
    h3_side_r  <= mws_pkg::side_advance(h2_side_r, rst_n);
    h3_pre_r   <= h2_pre_r;
    h3_ty_r    <= ty_nxt;
    h3_f_r     <= f_nxt;
    h4_side_r  <= mws_pkg::side_advance(h3_side_r, rst_n);
    h4_pre_r   <= h3_pre_r;
    h4_yclip_r <= yclip_nxt;
    h4_ph_r    <= ph_nxt;
    h5_side_r  <= mws_pkg::side_advance(h4_side_r, rst_n);
    h5_pre_r   <= h4_pre_r;
    h5_yclip_r <= h4_yclip_r;
    h6_side_r  <= mws_pkg::side_advance(h5_side_r, rst_n);
    h6_y_r     <= y_nxt;
  end

  assign shaped.side = h6_side_r;
  assign shaped.y    = h6_y_r;

endmodule

### hdl/mws_mixer.sv
module mws_mixer #(
  parameter int SAMPLE_BITS = mws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mws_pkg::shaped_t              shaped,
  input  mws_pkg::cfg_t                 cfg,
  output logic                          res_valid,
  output logic signed [SAMPLE_BITS+1:0] res_sample
);

  localparam int OSH = mws_pkg::IFRAC + 1 - SAMPLE_BITS;
  localparam int OW  = SAMPLE_BITS + 2;
  localparam logic signed [32:0] OMAX = 33'((longint'(1) << (SAMPLE_BITS + 1)) - 1);
  localparam logic signed [32:0] OMIN = -OMAX - 33'sd1;

  mws_pkg::side_t     m1_side_r, m2_side_r, m3_side_r;
  logic signed [31:0] m1_wet_r;
  logic signed [31:0] m2_wet_r;
  logic signed [24:0] m2_dry_r;
  logic signed [32:0] m3_mix_r;
  logic               out_valid_r;
  logic signed [OW-1:0] out_sample_r;

  logic [14:0]        gv;
  logic signed [45:0] wprod;
  logic [12:0]        cb;
  logic signed [45:0] bprod;
  logic signed [38:0] dprod;
  logic signed [32:0] mix;
  logic signed [54:0] gprod;
  logic signed [32:0] mix_nxt;
  logic signed [32:0] rm;
  logic signed [OW-1:0] out_nxt;

  always_comb begin
    gv    = 15'(cfg.volume) + 15'({cfg.volume, 1'b0}) + 15'd4096;
    wprod = shaped.y * $signed({1'b0, gv});
    cb    = 13'd4096 - cfg.blend;
    bprod = m1_wet_r * $signed({1'b0, cfg.blend});
    dprod = m1_side_r.clean * $signed({1'b0, cb});
    mix   = 33'(m2_wet_r) + 33'(m2_dry_r);
    gprod = mix * mws_pkg::GATE_Q;
    mix_nxt = m2_side_r.gated ? 33'(mws_pkg::round_shift(64'(gprod), 24)) : mix;
    rm = 33'(mws_pkg::round_shift(64'(m3_mix_r), OSH));
    if (cfg.bypass) begin
      out_nxt = OW'(m3_side_r.clean >>> OSH);
    end else if (rm > OMAX) begin
      out_nxt = OW'(OMAX);
    end else if (rm < OMIN) begin
      out_nxt = OW'(OMIN);
    end else begin
      out_nxt = OW'(rm);
    end
  end

  always_ff @(posedge clk) begin
    m1_side_r    <= mws_pkg::side_advance(shaped.side, rst_n);
    m1_wet_r     <= 32'(mws_pkg::round_shift(64'(wprod), 13));
    m2_side_r    <= mws_pkg::side_advance(m1_side_r, rst_n);
    m2_wet_r     <= 32'(mws_pkg::round_shift(64'(bprod), 12));
    m2_dry_r     <= 25'(mws_pkg::round_shift(64'(dprod), 12));
    m3_side_r    <= mws_pkg::side_advance(m2_side_r, rst_n);
    m3_mix_r     <= mix_nxt;
    out_valid_r  <= m3_side_r.valid && rst_n;
    out_sample_r <= out_nxt;
  end

  assign res_valid  = out_valid_r;
  assign res_sample = out_sample_r;

endmodule

### hdl/multimode_waveshaper.sv
// An accepted request's result reaches the output ports through every pipeline register.
// Throughput: one request per cycle; busy is high only in reset and the first cycle after it.
// The pipeline registers are three pre-gain stages, six shaping stages (two of
// them registered table reads) and four volume, mix and rounding stages.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
// Each result strobes out_valid for one cycle; the receiver cannot stall it.
module multimode_waveshaper #(
  parameter int SAMPLE_BITS = mws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample_in,
  output logic                                  out_valid,
  output logic signed [SAMPLE_BITS+1:0]         out_sample_out,
  input  logic                                  cfg_wr_en,
  input  logic [mws_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mws_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // Configuration registers, held exactly as written.
  logic [13:0] drive_r, drive_nxt;
  logic [14:0] range_r, range_nxt;
  logic [12:0] blend_r, blend_nxt;
  logic [13:0] volume_r, volume_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        bypass_r, bypass_nxt;
  logic        busy_r;

  mws_pkg::cfg_t    cfg;
  mws_pkg::front_t  front;
  mws_pkg::shaped_t shaped;

  // A write lands at the edge where the enable is high. Indexes beyond the list are dropped.
  always_comb begin
    drive_nxt  = drive_r;
    range_nxt  = range_r;
    blend_nxt  = blend_r;
    volume_nxt = volume_r;
    mode_nxt   = mode_r;
    bypass_nxt = bypass_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        mws_pkg::REG_DRIVE:  drive_nxt  = cfg_data[13:0];
        mws_pkg::REG_RANGE:  range_nxt  = cfg_data[14:0];
        mws_pkg::REG_BLEND:  blend_nxt  = cfg_data[12:0];
        mws_pkg::REG_VOLUME: volume_nxt = cfg_data[13:0];
        mws_pkg::REG_MODE:   mode_nxt   = cfg_data[1:0];
        mws_pkg::REG_BYPASS: bypass_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r  <= 14'd2048;
      range_r  <= 15'd4096;
      blend_r  <= 13'd3277;
      volume_r <= 14'd4096;
      mode_r   <= mws_pkg::MODE_TANH;
      bypass_r <= 1'b0;
      busy_r   <= 1'b1;
    end else begin
      drive_r  <= drive_nxt;
      range_r  <= range_nxt;
      blend_r  <= blend_nxt;
      volume_r <= volume_nxt;
      mode_r   <= mode_nxt;
      bypass_r <= bypass_nxt;
      busy_r   <= 1'b0;
    end
  end

  // A setting above its high value acts as the high value. Every stage reads the settings
  // directly; the user must change them only while the pipeline is empty (not enforced).
  always_comb begin
    cfg.drive  = (drive_r > 14'd8192) ? 14'd8192 : drive_r;
    cfg.range  = (range_r > 15'd20480) ? 15'd20480 : range_r;
    cfg.blend  = (blend_r > 13'd4096) ? 13'd4096 : blend_r;
    cfg.volume = (volume_r > 14'd8192) ? 14'd8192 : volume_r;
    cfg.mode   = mws_pkg::mode_t'(mode_r);
    cfg.bypass = bypass_r;
  end

  assign busy = busy_r;

  // Gate and pre-gain, then the tanh argument and the square for the fold curve.
  mws_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (start && !busy_r),
    .sample (in_sample_in),
    .cfg    (cfg),
    .front  (front)
  );

  // The tanh and fold paths run side by side; the mode picks one or the bare pre-gain value.
  mws_shaper u_shaper (
    .clk    (clk),
    .rst_n  (rst_n),
    .front  (front),
    .cfg    (cfg),
    .shaped (shaped)
  );

  // Volume, dry/wet blend, second gate pass, rounding and saturation, bypass.
  mws_mixer #(.SAMPLE_BITS(SAMPLE_BITS)) u_mixer (
    .clk        (clk),
    .rst_n      (rst_n),
    .shaped     (shaped),
    .cfg        (cfg),
    .res_valid  (out_valid),
    .res_sample (out_sample_out)
  );

endmodule

### hdl/mws_checker.sv
module mws_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  localparam int LAT = mws_pkg::PIPE_LATENCY;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // Once out of reset the block never refuses a request.
  a_never_busy: assert property (@(posedge clk) rst_n |=> !busy)
    else $error("busy raised outside reset");

  // Every accepted request gives its result after the pipeline depth.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after accepted request");

  // No result appears without a request that depth earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a request");

endmodule

bind multimode_waveshaper mws_checker u_mws_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

### test/multimode_waveshaper_tb.sv
module multimode_waveshaper_tb;

  // Sample-level predictor of the waveshaper plus the queue of shaped samples
  // still owed by the pipeline. It keeps its own copy of the settings.
  class waveshape_checker;
    longint tanh_tab[0:512];
    longint sine_tab[0:256];
    int unsigned drive_r, range_r, blend_r, volume_r;
    mws_pkg::mode_t mode_r;
    bit bypass_r;
    logic signed [17:0] owed_samples[$];
    int errors;

    function new();
      longint one30, term, ratio, ex, den, th, th2, t, acc, d;
      one30 = longint'(1) << 30;
      term = one30;
      ratio = one30;
      ex = one30;
      // The decay ratio exp(-1/32) comes from its series, then tanh = (1-e)/(1+e).
      for (int n = 1; n <= 8; n++) begin
        term = (term + 16 * n) / (32 * n);
        ratio = (n % 2 == 1) ? ratio - term : ratio + term;
      end
      for (int k = 0; k <= 512; k++) begin
        den = one30 + ex;
        tanh_tab[k] = (((one30 - ex) << 24) + den / 2) / den;
        ex = (ex * ratio + (one30 >>> 1)) >>> 30;
      end
      // Quarter-wave sine from a truncated Taylor series in Q.30.
      for (int k = 0; k <= 256; k++) begin
        th = (64'sd3373259426 * k + 256) / 512;
        th2 = (th * th + (one30 >>> 1)) >>> 30;
        t = th;
        acc = th;
        for (int n = 1; n <= 9; n++) begin
          d = longint'(2 * n) * (2 * n + 1);
          t = (t * th2 + (one30 >>> 1)) >>> 30;
          t = (t + d / 2) / d;
          acc = (n % 2 == 1) ? acc - t : acc + t;
        end
        sine_tab[k] = (acc + 32) >>> 6;
      end
      clear_regs();
      errors = 0;
    endfunction

    function void clear_regs();
      drive_r = 2048;
      range_r = 4096;
      blend_r = 3277;
      volume_r = 4096;
      mode_r = mws_pkg::MODE_TANH;
      bypass_r = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [14:0] data);
      case (idx)
        mws_pkg::REG_DRIVE:  drive_r = data[13:0];
        mws_pkg::REG_RANGE:  range_r = data[14:0];
        mws_pkg::REG_BLEND:  blend_r = data[12:0];
        mws_pkg::REG_VOLUME: volume_r = data[13:0];
        mws_pkg::REG_MODE:   mode_r = mws_pkg::mode_t'(data[1:0]);
        mws_pkg::REG_BYPASS: bypass_r = data[0];
        default: ;
      endcase
    endfunction

    function longint unsigned mag(longint a);
      return (a < 0) ? longint'(-a) : a;
    endfunction

    // Product scaled down by 2^sh, rounded to nearest with ties away from zero.
    function longint mul_round(longint a, longint b, int sh);
      longint unsigned p, r;
      p = mag(a) * mag(b);
      r = (p + (64'd1 << (sh - 1))) >> sh;
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function longint tanh_fx(longint a);
      longint unsigned m, idx, fr;
      longint v;
      m = mag(a);
      if (m >= (64'd8 << 24)) begin
        v = tanh_tab[512];
      end else begin
        idx = m >> 18;
        fr = m & 64'h3FFFF;
        v = tanh_tab[idx] + (((tanh_tab[idx + 1] - tanh_tab[idx]) * longint'(fr)
            + 64'sh20000) >>> 18);
      end
      return (a < 0) ? -v : v;
    endfunction

    // Sine of u half-turns; the phase wraps every two half-turns.
    function longint sine_fx(longint u);
      longint unsigned p, idx, fr;
      longint v;
      bit neg;
      p = longint'(u) & ((64'd2 << 24) - 1);
      neg = p >= (64'd1 << 24);
      if (neg) p = p - (64'd1 << 24);
      if (p > (64'd1 << 23)) p = (64'd1 << 24) - p;
      idx = p >> 15;
      fr = p & 64'h7FFF;
      if (idx >= 256) begin
        v = sine_tab[256];
      end else begin
        v = sine_tab[idx] + (((sine_tab[idx + 1] - sine_tab[idx]) * longint'(fr)
            + 64'sh4000) >>> 15);
      end
      return neg ? -v : v;
    endfunction

    function longint clamp_09(longint v);
      if (v > 15099494) return 15099494;
      if (v < -15099494) return -15099494;
      return v;
    endfunction

    function logic signed [17:0] shape_sample(logic signed [15:0] s_in);
      longint s, x, clean, pre, y, mix, res, drv, rng, bln, vol, cube, fold;
      bit gated;
      s = s_in;
      if (bypass_r) return 18'(s);
      drv = (drive_r > 8192) ? 8192 : drive_r;
      rng = (range_r > 20480) ? 20480 : range_r;
      bln = (blend_r > 4096) ? 4096 : blend_r;
      vol = (volume_r > 8192) ? 8192 : volume_r;
      x = s * 512;
      gated = mag(x) < 167772;
      clean = gated ? mul_round(x, 1677722, 24) : x;
      pre = mul_round(clean, rng * 5, 12);
      case (mode_r)
        mws_pkg::MODE_TANH:
          y = mul_round(tanh_fx(mul_round(pre, 4096 + drv, 12)), 15099494, 24);
        mws_pkg::MODE_CLIP: begin
          y = mul_round(tanh_fx(mul_round(pre, 10066330, 24)), 30198989, 24);
          y = clamp_09(mul_round(y, 4096 + 2 * drv, 12));
        end
        mws_pkg::MODE_FOLD: begin
          cube = mul_round(mul_round(pre, pre, 24), pre, 24);
          fold = pre - mul_round(cube, 3355443, 24);
          y = clamp_09(sine_fx(mul_round(fold, 4096 + drv, 13)));
        end
        default: y = pre;
      endcase
      y = mul_round(y, 4096 + 3 * vol, 13);
      mix = mul_round(y, bln, 12) + mul_round(clean, 4096 - bln, 12);
      if (gated) mix = mul_round(mix, 1677722, 24);
      res = mul_round(mix, 1, 9);
      if (res > 131071) res = 131071;
      if (res < -131072) res = -131072;
      return 18'(res);
    endfunction

    function void note_request(logic signed [15:0] s_in);
      owed_samples.push_back(shape_sample(s_in));
    endfunction

    function void check_result(logic signed [17:0] got);
      logic signed [17:0] want;
      if (owed_samples.size() == 0) begin
        $error("sample_out: no result expected, actual %0d", got);
        errors++;
      end else begin
        want = owed_samples.pop_front();
        if (got !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_sample_in = '0;
  logic out_valid;
  logic signed [17:0] out_sample_out;
  logic cfg_wr_en = 1'b0;
  logic [mws_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mws_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  waveshape_checker chk = new();
  int idle_pct;
  int quiet_cycles = 0;

  localparam int QUIET_LIMIT = 2000;

  multimode_waveshaper uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_in(in_sample_in), .out_valid(out_valid), .out_sample_out(out_sample_out),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Everything the block accepts is mirrored into the checker at the same edge.
  // Register writes only happen while the pipeline is empty, so their order
  // against requests and results within one edge does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) chk.set_reg(cfg_index, cfg_data);
      if (start && !busy) chk.note_request(in_sample_in);
      if (out_valid) chk.check_result(out_sample_out);
    end
  end

  // Watchdog: a long stretch with neither a request nor a result means a hang.
  always @(posedge clk) begin
    if (rst_n && !((start && !busy) || out_valid)) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("multimode_waveshaper regression: fail");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Called at a falling edge. Holds the request until the edge where busy is low,
  // then returns at a later falling edge; each following cycle is idle with the
  // phase's idle share.
  task automatic send_request(logic signed [15:0] value);
    bit taken;
    start <= 1'b1;
    in_sample_in <= value;
    taken = 1'b0;
    while (!taken) begin
      taken = !busy;
      @(negedge clk);
    end
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_sample_in <= 16'($urandom);
      @(negedge clk);
    end
  endtask

  // Lowers start and waits until the pipeline has delivered everything owed,
  // then waits out the pipeline latency again so that a stray result would show.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(negedge clk);
    while (chk.owed_samples.size() != 0) @(negedge clk);
    repeat (mws_pkg::PIPE_LATENCY + 4) @(negedge clk);
  endtask

  // Writes all six registers on consecutive cycles, then one stray index that
  // the block must ignore. The enable is lowered once at the end of the burst.
  task automatic load_settings(int drv, int rng, int bln, int vol, int mode, int byp);
    int vals[6];
    vals = '{drv, rng, bln, vol, mode, byp};
    for (int i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= mws_pkg::CFG_IDX_W'(i);
      cfg_data <= mws_pkg::CFG_DATA_W'(vals[i]);
      @(negedge clk);
    end
    cfg_index <= mws_pkg::CFG_IDX_W'($urandom_range(6, 7));
    cfg_data <= mws_pkg::CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Random sample: full range, near the gate threshold, near full scale or mid level.
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 800)) - 400);
      2: return $urandom_range(1) ? 16'sd32767 - 16'($urandom_range(64))
                                  : 16'sh8000 + 16'($urandom_range(64));
      default: return 16'($signed($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // The directed set: both full-scale ends, zero, one LSB each way, the two sides of
  // the noise-gate threshold in each polarity and three mid-level points.
  task automatic directed_burst();
    logic signed [15:0] pts[12];
    pts = '{16'sd32767, 16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd327, 16'sd328,
            -16'sd327, -16'sd328, 16'sd16384, -16'sd6554, 16'sd21845};
    foreach (pts[i]) send_request(pts[i]);
  endtask

  initial begin
    int phase_pct[4];
    int drv, rng, bln, vol, mode;
    phase_pct = '{0, 67, 0, 36};
    idle_pct = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults first, with no write, then directed points per mode and
    // at the register extremes, including values past their documented highs.
    directed_burst();
    for (int m = 0; m < 4; m++) begin
      drain_pipeline();
      load_settings(8192, 20480, 4096, 8192, m, 0);
      directed_burst();
    end
    drain_pipeline();
    load_settings(0, 0, 0, 0, mws_pkg::MODE_FOLD, 0);
    directed_burst();
    drain_pipeline();
    load_settings(16383, 32767, 8191, 16383, mws_pkg::MODE_CLIP, 0);
    directed_burst();
    drain_pipeline();
    load_settings(2048, 4096, 3277, 4096, mws_pkg::MODE_TANH, 1);
    directed_burst();

    // Random phases: each draws new settings, mostly in range, sometimes at an
    // edge or beyond, and cycles through the idling profiles.
    for (int ph = 0; ph < 12; ph++) begin
      drain_pipeline();
      idle_pct = phase_pct[ph % 4];
      drv = ($urandom_range(3) == 0) ? 16383 * $urandom_range(1) : $urandom_range(8192);
      rng = ($urandom_range(3) == 0) ? 32767 * $urandom_range(1) : $urandom_range(20480);
      bln = ($urandom_range(3) == 0) ? 8191 * $urandom_range(1) : $urandom_range(4096);
      vol = ($urandom_range(3) == 0) ? 16383 * $urandom_range(1) : $urandom_range(8192);
      mode = ph % 4;
      load_settings(drv, rng, bln, vol, mode, ($urandom_range(7) == 0));
      for (int i = 0; i < 90; i++) begin
        send_request(pick_sample());
        // Once per phase the sender holds off until the pipeline runs dry.
        if (i == 45) drain_pipeline();
      end
    end

    start <= 1'b0;
    while (chk.owed_samples.size() != 0) @(negedge clk);
    repeat (mws_pkg::PIPE_LATENCY + 4) @(negedge clk);
    if (chk.errors == 0) begin
      $display("multimode_waveshaper regression: pass");
    end else begin
      $display("multimode_waveshaper regression: fail");
    end
    $finish;
  end
endmodule

### multimode_waveshaper.f
hdl/mws_pkg.sv
hdl/mws_front.sv
hdl/mws_shaper.sv
hdl/mws_mixer.sv
hdl/multimode_waveshaper.sv
hdl/mws_checker.sv
test/multimode_waveshaper_tb.sv
